/* hdl/mbtp_pkg.sv */
// shared types and constants for the modbus tcp request parser
// no dependencies; compiled first
package mbtp_pkg;

    localparam int RES_FIFO_DEPTH = 4;

    localparam int POS_W = 17;

    // byte positions inside the mbap header and pdu
    localparam logic [POS_W-1:0] POS_TID_HI     = 17'd0;
    localparam logic [POS_W-1:0] POS_TID_LO     = 17'd1;
    localparam logic [POS_W-1:0] POS_PROTO_HI   = 17'd2;
    localparam logic [POS_W-1:0] POS_PROTO_LO   = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_HI     = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO     = 17'd5;
    localparam logic [POS_W-1:0] POS_UNIT       = 17'd6;
    localparam logic [POS_W-1:0] POS_FUNC       = 17'd7;
    localparam logic [POS_W-1:0] POS_ADDR_HI    = 17'd8;
    localparam logic [POS_W-1:0] POS_ADDR_LO    = 17'd9;
    localparam logic [POS_W-1:0] POS_QTY_HI     = 17'd10;
    localparam logic [POS_W-1:0] POS_QTY_LO     = 17'd11;
    localparam logic [POS_W-1:0] POS_BCOUNT     = 17'd12;
    localparam logic [POS_W-1:0] POS_DATA       = 17'd13;

    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

    localparam logic [15:0] QTY_MAX_READ_BITS  = 16'h07D0;
    localparam logic [15:0] QTY_MAX_READ_REGS  = 16'h007D;
    localparam logic [15:0] QTY_MAX_WRITE_BITS = 16'h07B0;
    localparam logic [15:0] QTY_MAX_WRITE_REGS = 16'h007B;
    localparam logic [15:0] COIL_ON            = 16'hFF00;
    localparam logic [15:0] COIL_OFF           = 16'h0000;

    localparam logic [15:0] LEN_MIN = 16'd6;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FUNC  = 2'd1,
        ST_BAD_VALUE = 2'd2
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] transaction_id;
        logic [7:0]  unit_number;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [10:0] item_count;
        logic [15:0] data_value;
        logic [4:0]  valid_bits;
        t_status     status;
        logic        last;
    } t_result;

    // up to two results per byte; second is only pushed with first
    typedef struct packed {
        logic    push_first;
        logic    push_second;
        t_result first;
        t_result second;
    } t_push;

endpackage

/* hdl/mbtp_channels.sv */
// valid/ready channel interfaces for the modbus tcp request parser
// byte stream in, result words out; no package dependency
interface mbtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbtp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] transaction_id;
    logic [7:0]  unit_number;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [10:0] item_count;
    logic [15:0] data_value;
    logic [4:0]  valid_bits;
    logic [1:0]  status;
    logic        last;

    modport source (
        output valid, output kind, output transaction_id, output unit_number,
        output function_code, output start_address, output item_count,
        output data_value, output valid_bits, output status, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input transaction_id, input unit_number,
        input function_code, input start_address, input item_count,
        input data_value, input valid_bits, input status, input last,
        output ready
    );
endinterface

/* hdl/mbtp_decoder.sv */
// per-byte frame decoder: mbap/pdu field capture, request checks, result build
// depends on mbtp_pkg
module mbtp_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    output mbtp_pkg::t_push       o_push,
    output logic                  o_halted
);
    import mbtp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_tid, n_tid;
    logic [7:0]       r_unit, n_unit;
    logic [7:0]       r_func, n_func;
    logic [15:0]      r_addr, n_addr;
    logic [15:0]      r_qty, n_qty;
    t_status          r_status, n_status;
    logic [7:0]       r_high, n_high;
    logic             r_halted, n_halted;
    logic             r_proto_bad, n_proto_bad;

    t_status          frame_status;
    logic             fault;
    logic             data_push;
    logic             done;
    logic [15:0]      data_val;
    logic [4:0]       data_vb;
    t_result          base;
    logic [POS_W-1:0] offset;
    logic [11:0]      remaining;
    logic [3:0]       coil_bits;
    logic [7:0]       coil_mask;
    logic [POS_W-1:0] expect_count;
    logic [POS_W-1:0] end_pos;

    function automatic logic qty_fits(input logic [15:0] qty, input logic [15:0] limit);
        return (qty != 16'd0) && (qty <= limit);
    endfunction

    function automatic t_status check_header(input logic [7:0] func, input logic [15:0] qty,
                                             input logic [15:0] len);
        logic exact;
        t_status st;
        exact = (len == LEN_MIN);
        case (func)
            FC_READ_COILS, FC_READ_DISCRETE:
                st = (exact && qty_fits(qty, QTY_MAX_READ_BITS)) ? ST_OK : ST_BAD_VALUE;
            FC_READ_HOLDING, FC_READ_INPUT:
                st = (exact && qty_fits(qty, QTY_MAX_READ_REGS)) ? ST_OK : ST_BAD_VALUE;
            FC_WRITE_COIL:
                st = (exact && (qty == COIL_OFF || qty == COIL_ON)) ? ST_OK : ST_BAD_VALUE;
            FC_WRITE_REG:
                st = exact ? ST_OK : ST_BAD_VALUE;
            FC_WRITE_COILS:
                st = (!exact && qty_fits(qty, QTY_MAX_WRITE_BITS)) ? ST_OK : ST_BAD_VALUE;
            FC_WRITE_REGS:
                st = (!exact && qty_fits(qty, QTY_MAX_WRITE_REGS)) ? ST_OK : ST_BAD_VALUE;
            default:
                st = ST_BAD_FUNC;
        endcase
        return st;
    endfunction

    // coil payload byte: mask off coils past the requested quantity
    assign offset    = r_pos - POS_DATA;
    assign remaining = {1'b0, r_qty[10:0]} - {1'b0, offset[7:0], 3'b000};
    assign coil_bits = (remaining > 12'd8) ? 4'd8 : remaining[3:0];
    assign coil_mask = 8'((9'd1 << coil_bits) - 9'd1);

    assign expect_count = (r_func == FC_WRITE_COILS)
                        ? ((POS_W'(r_qty) + POS_W'(7)) >> 3)
                        : {r_qty, 1'b0};
    assign end_pos = POS_W'(r_len) + POS_W'(5);

    always_comb begin
        n_pos        = r_pos;
        n_len        = r_len;
        n_tid        = r_tid;
        n_unit       = r_unit;
        n_func       = r_func;
        n_addr       = r_addr;
        n_qty        = r_qty;
        n_high       = r_high;
        n_halted     = r_halted;
        n_proto_bad  = r_proto_bad;
        frame_status = r_status;
        fault        = 1'b0;
        data_push    = 1'b0;
        done         = 1'b0;
        data_val     = 16'd0;
        data_vb      = 5'd0;

        if (i_accept && !r_halted) begin
            case (r_pos)
                POS_TID_HI:   n_tid = {i_rx_byte, 8'h00};
                POS_TID_LO:   n_tid = {r_tid[15:8], i_rx_byte};
                POS_PROTO_HI: n_proto_bad = (i_rx_byte != 8'd0);
                POS_PROTO_LO: n_proto_bad = r_proto_bad || (i_rx_byte != 8'd0);
                POS_LEN_HI:   n_len = {i_rx_byte, 8'h00};
                POS_LEN_LO:   n_len = {r_len[15:8], i_rx_byte};
                POS_UNIT:     n_unit = i_rx_byte;
                POS_FUNC:     n_func = i_rx_byte;
                POS_ADDR_HI:  n_addr = {i_rx_byte, 8'h00};
                POS_ADDR_LO:  n_addr = {r_addr[15:8], i_rx_byte};
                POS_QTY_HI:   n_qty = {i_rx_byte, 8'h00};
                POS_QTY_LO: begin
                    n_qty = {r_qty[15:8], i_rx_byte};
                    if (r_proto_bad || r_len < LEN_MIN) begin
                        fault    = 1'b1;
                        n_halted = 1'b1;
                    end else begin
                        frame_status = check_header(r_func, n_qty, r_len);
                        if (frame_status == ST_OK && r_len == LEN_MIN) begin
                            if (r_func == FC_WRITE_COIL) begin
                                data_push = 1'b1;
                                data_val  = {15'd0, n_qty == COIL_ON};
                                data_vb   = 5'd1;
                            end else if (r_func == FC_WRITE_REG) begin
                                data_push = 1'b1;
                                data_val  = n_qty;
                                data_vb   = 5'd16;
                            end
                        end
                    end
                end
                POS_BCOUNT: begin
                    if (r_status == ST_OK) begin
                        if (POS_W'(i_rx_byte) != expect_count
                                || r_len != 16'(i_rx_byte) + 16'd7) begin
                            frame_status = ST_BAD_VALUE;
                        end
                    end
                end
                default: begin
                    if (r_status == ST_OK && r_func == FC_WRITE_REGS) begin
                        if (!offset[0]) begin
                            n_high = i_rx_byte;
                        end else begin
                            data_push = 1'b1;
                            data_val  = {r_high, i_rx_byte};
                            data_vb   = 5'd16;
                        end
                    end else if (r_status == ST_OK && r_func == FC_WRITE_COILS) begin
                        data_push = 1'b1;
                        data_val  = {8'd0, i_rx_byte & coil_mask};
                        data_vb   = {1'b0, coil_bits};
                    end
                end
            endcase

            if (!fault) begin
                if (r_pos >= POS_QTY_LO && r_pos == end_pos) begin
                    done  = 1'b1;
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end

        n_status    = done ? ST_OK : frame_status;
        n_proto_bad = done ? 1'b0 : n_proto_bad;
    end

    // fields shared by every item of the frame
    always_comb begin
        base                = '0;
        base.transaction_id = n_tid;
        base.unit_number    = n_unit;
        base.function_code  = n_func;
        base.start_address  = n_addr;
        if (frame_status != ST_OK) begin
            base.item_count = 11'd0;
        end else if (n_func == FC_WRITE_COIL || n_func == FC_WRITE_REG) begin
            base.item_count = 11'd1;
        end else begin
            base.item_count = n_qty[10:0];
        end
    end

    always_comb begin
        o_push             = '0;
        o_push.push_first  = data_push || done || fault;
        o_push.push_second = data_push && done;
        if (fault) begin
            o_push.first      = '0;
            o_push.first.kind = KIND_FAULT;
            o_push.first.last = 1'b1;
        end else if (data_push) begin
            o_push.first            = base;
            o_push.first.kind       = KIND_DATA;
            o_push.first.data_value = data_val;
            o_push.first.valid_bits = data_vb;
        end else begin
            o_push.first        = base;
            o_push.first.kind   = KIND_DONE;
            o_push.first.status = frame_status;
            o_push.first.last   = 1'b1;
        end
        o_push.second        = base;
        o_push.second.kind   = KIND_DONE;
        o_push.second.status = frame_status;
        o_push.second.last   = 1'b1;
    end

    assign o_halted = r_halted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_len        <= '0;
            r_tid        <= '0;
            r_unit       <= '0;
            r_func       <= '0;
            r_addr       <= '0;
            r_qty        <= '0;
            r_status     <= ST_OK;
            r_high       <= '0;
            r_halted     <= 1'b0;
            r_proto_bad  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_tid        <= n_tid;
            r_unit       <= n_unit;
            r_func       <= n_func;
            r_addr       <= n_addr;
            r_qty        <= n_qty;
            r_status     <= n_status;
            r_high       <= n_high;
            r_halted     <= n_halted;
            r_proto_bad  <= n_proto_bad;
        end
    end

endmodule

/* hdl/mbtp_res_fifo.sv */
// result queue: two writes, one read per cycle
// depends on mbtp_pkg
module mbtp_res_fifo #(
    parameter int DEPTH = mbtp_pkg::RES_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbtp_pkg::t_push   i_push,
    input  logic              i_pop,
    output mbtp_pkg::t_result o_head,
    output logic              o_valid,
    output logic              o_room
);
    import mbtp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wr_plus1;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_plus1 = bump(r_wr);

    always_comb begin
        if (i_push.push_second) begin
            n_wr = bump(wr_plus1);
        end else if (i_push.push_first) begin
            n_wr = wr_plus1;
        end else begin
            n_wr = r_wr;
        end
        n_rd    = i_pop ? bump(r_rd) : r_rd;
        n_count = r_count + CNT_W'(i_push.push_first) + CNT_W'(i_push.push_second)
                - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_first) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.push_second) begin
            r_mem[wr_plus1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    // two free slots, since one byte can make two words
    assign o_room  = (r_count <= ROOM_MAX);

endmodule

/* hdl/modbus_tcp_request_parser.sv */
// modbus tcp request parser top level: byte decoder feeding a result queue
// depends on mbtp_pkg, mbtp_channels, mbtp_decoder, mbtp_res_fifo
//
//  channel  dir  modport  payload
//  i_rx     in   sink     rx_byte
//  o_res    out  source   kind, transaction_id, unit_number, function_code,
//                         start_address, item_count, data_value, valid_bits,
//                         status, last
//
// one byte per cycle while i_rx.ready is high; its words enter the queue at the accepting edge and
// show on o_res in the following cycle at the earliest
// a byte makes zero, one or two words; i_rx.ready drops while the queue has
// fewer than two free slots (FIFO_DEPTH entries), so stalls on o_res push back
// synchronous reset clears position, held fields, halt flag and the queue
// after a framing fault bytes are still taken but dropped until reset
module modbus_tcp_request_parser #(
    parameter int FIFO_DEPTH = mbtp_pkg::RES_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbtp_byte_if.sink   i_rx,
    mbtp_result_if.source o_res
);
    import mbtp_pkg::*;

    t_push   push;
    t_result head;
    logic    accept;
    logic    halted;
    logic    head_valid;
    logic    room;

    assign i_rx.ready = room;
    assign accept     = i_rx.valid && room;

    mbtp_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx.rx_byte),
        .o_push    (push),
        .o_halted  (halted)
    );

    mbtp_res_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (head_valid && o_res.ready),
        .o_head  (head),
        .o_valid (head_valid),
        .o_room  (room)
    );

    assign o_res.valid          = head_valid;
    assign o_res.kind           = head.kind;
    assign o_res.transaction_id = head.transaction_id;
    assign o_res.unit_number    = head.unit_number;
    assign o_res.function_code  = head.function_code;
    assign o_res.start_address  = head.start_address;
    assign o_res.item_count     = head.item_count;
    assign o_res.data_value     = head.data_value;
    assign o_res.valid_bits     = head.valid_bits;
    assign o_res.status         = head.status;
    assign o_res.last           = head.last;

`ifndef ASSERT_OFF
    // a byte only makes two words as data then completion
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push_second |-> push.push_first && push.first.kind == KIND_DATA
            && !push.first.last && push.second.kind == KIND_DONE && push.second.last)
        else $error("two words from one byte not data then completion");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        halted |=> halted)
        else $error("halt released without reset");

    // a fault word always sets the halt and nothing follows it from the decoder
    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push_first && push.first.kind == KIND_FAULT |=> halted && !push.push_first)
        else $error("fault word without halt");
`endif

endmodule
